>>> src/assert_macros.svh
// assertion macros shared by the list rtl
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge outside reset
`define BAL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication, consequent checked at the next edge
`define BAL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bal_pkg.sv
// package for the bounded array list: field widths, command codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package bal_pkg;

   localparam int DEFAULT_CAPACITY = 32;

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_SHIFT,
      ST_READ,
      ST_READ_WAIT
   } state_type;

endpackage

>>> src/bal_ram.sv
// single-port-write, single-port-read entry store with registered read data
// uses bal_pkg for the data width
`timescale 1ns / 1ps

module bal_ram #(
   parameter int DEPTH = bal_pkg::DEFAULT_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [bal_pkg::VALUE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [bal_pkg::VALUE_W-1:0] rd_data
);
   import bal_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bounded_array_list.sv
// bounded array list: an insertion-ordered list of up to CAPACITY signed 32-bit values.
// a command appends a value, removes the first equal value (later entries shift down)
// or reads the entry at a position; each command returns exactly one result with the
// outcome, the value read, the new count and empty/full flags. one command is worked
// at a time. every access goes through the single-read, single-write entry memory,
// whose one read port and one equality compare are reused by a small sequencer.
// sequencer path after the input transfer: append, unused command code, remove on an
// empty list and read at or past the count finish from the execute state; a read goes
// on through a read and a read-wait state; a remove searches the memory one entry a
// cycle and, on a match, the shift moves each later entry down one a cycle.
// a new input transfer is taken from the cycle after the previous result transfer.
// a failed command (full on append, empty or not found on remove, position at or
// past the count on read, unused command code) leaves the list unchanged.
// depends on bal_pkg, bal_ram and assert_macros.svh
`timescale 1ns / 1ps

module bounded_array_list #(
   parameter int CAPACITY = bal_pkg::DEFAULT_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cmd [1:0], value [33:2], position [38:34], zero fill [39]
   input  logic [bal_pkg::REQ_TDATA_W-1:0] req_tdata,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // ok [0], read_value [32:1], count [38:33], is_empty [39], is_full [40],
   // zero fill [47:41]
   output logic [bal_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bal_pkg::*;

`include "assert_macros.svh"

   // fill holds 0..CAPACITY, the memory address 0..CAPACITY-1
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [FW-1:0] FULL_COUNT = FW'(CAPACITY);

   // sequencer state
   state_type state_ff, state_in;

   // latched command (payload, no reset)
   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;

   // list bookkeeping
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] idx_ff, idx_in;   // walk index: search address, shift target, read position
   logic          chk_ff, chk_in;   // read data holds entry idx_ff - 1 during search

   // result register
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [VALUE_W-1:0] rsp_rdval_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_empty_ff;
   logic               rsp_full_ff;

   // memory port
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   // finish strobe and result payload
   logic               finish;
   logic               fin_ok;
   logic [VALUE_W-1:0] fin_rdval;

   // shared compare and walk arithmetic
   logic               req_xfer;
   logic               rsp_xfer;
   logic               hit;
   logic               is_full_now;
   logic               walk_done;
   logic               more_to_shift;
   logic               pos_in_range;
   logic [FW:0]        idx_plus1;
   logic [FW:0]        idx_plus2;
   logic [FW+POS_W-1:0] pos_wide;
   logic [FW+POS_W-1:0] fill_wide;
   logic [FW+COUNT_W-1:0] cnt_wide;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;

   assign hit         = chk_ff && (ram_rd_data == value_ff);
   assign is_full_now = (fill_ff == FULL_COUNT);
   assign walk_done   = chk_ff && (idx_ff == fill_ff);
   assign idx_plus1   = {1'b0, idx_ff} + {{FW{1'b0}}, 1'b1};
   assign idx_plus2   = {1'b0, idx_ff} + (FW+1)'(2);
   assign more_to_shift = (idx_plus1 < {1'b0, fill_ff});
   assign pos_wide    = {{FW{1'b0}}, pos_ff};
   assign fill_wide   = {{POS_W{1'b0}}, fill_ff};
   assign pos_in_range = (pos_wide < fill_wide);
   assign cnt_wide    = {{COUNT_W{1'b0}}, fill_in};

   bal_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (cmd_ff == CMD_REMOVE && fill_ff != '0) begin
               state_in = ST_SEARCH;
            end else if (cmd_ff == CMD_READ && pos_in_range) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            priority if (hit) begin
               state_in = ST_SHIFT;
            end else if (walk_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SHIFT: begin
            if (!more_to_shift) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      chk_in      = chk_ff;
      finish      = 1'b0;
      fin_ok      = 1'b0;
      fin_rdval   = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = fill_ff[AW-1:0];
      ram_wr_data = value_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            idx_in = '0;
            chk_in = 1'b0;
            unique case (cmd_ff)
               CMD_APPEND: begin
                  finish = 1'b1;
                  if (!is_full_now) begin
                     // store at the tail, count grows by one
                     ram_wr_en = 1'b1;
                     fill_in   = fill_ff + {{(FW-1){1'b0}}, 1'b1};
                     fin_ok    = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  finish = (fill_ff == '0);
               end
               CMD_READ: begin
                  finish = !pos_in_range;
                  idx_in = pos_wide[FW-1:0];
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_SEARCH: begin
            // one address issued and one entry compared per cycle
            ram_rd_en = 1'b1;
            priority if (hit) begin
               // match at idx - 1; entry idx is being read for the shift
               idx_in = idx_plus1[FW-1:0] - (FW)'(2);
            end else if (walk_done) begin
               finish = 1'b1;
            end else begin
               idx_in = idx_plus1[FW-1:0];
               chk_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            // move entry idx + 1 down to idx, fetch idx + 2
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_plus2[AW-1:0];
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            if (more_to_shift) begin
               ram_wr_en = 1'b1;
               idx_in    = idx_plus1[FW-1:0];
            end else begin
               finish  = 1'b1;
               fin_ok  = 1'b1;
               fill_in = fill_ff - {{(FW-1){1'b0}}, 1'b1};
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
         end
         ST_READ_WAIT: begin
            finish    = 1'b1;
            fin_ok    = 1'b1;
            fin_rdval = ram_rd_data;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         chk_ff   <= chk_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_tdata[1:0];
         value_ff <= req_tdata[33:2];
         pos_ff   <= req_tdata[38:34];
      end
      if (finish) begin
         rsp_ok_ff    <= fin_ok;
         rsp_rdval_ff <= fin_rdval;
         rsp_count_ff <= cnt_wide[COUNT_W-1:0];
         rsp_empty_ff <= (fill_in == '0);
         rsp_full_ff  <= (fill_in == FULL_COUNT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_full_ff, rsp_empty_ff, rsp_count_ff, rsp_rdval_ff, rsp_ok_ff};

   // checks
   `BAL_ASSERT(a_fill_bound, clock, reset, fill_ff <= FULL_COUNT, "fill past capacity")
   `BAL_ASSERT(a_no_write_idle, clock, reset, (state_ff != ST_IDLE) || !ram_wr_en, "memory write while idle")
   `BAL_ASSERT_NEXT(a_rsp_drains, clock, reset, rsp_xfer, !rsp_tvalid, "result repeated after transfer")
   `BAL_ASSERT_NEXT(a_accept_exec, clock, reset, req_xfer, state_ff == ST_EXEC, "accepted command not executed")

endmodule

>>> verif/bounded_array_list_tb.sv
// self-checking testbench for bounded_array_list: directed and random list commands
// checked against an in-bench predictor of the list; depends on bal_pkg and the rtl
`timescale 1ns / 1ps

module bounded_array_list_tb;
   import bal_pkg::*;

   localparam int LIST_DEPTH = DEFAULT_CAPACITY;
   // command code with no operation behind it; the block must answer it with a failure
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // quiet tail after the last result, long enough to cover a full walk of the list
   localparam int TAIL_CYCLES = LIST_DEPTH + 8;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      bit                        drain;   // hold off until every expected result is back
   } list_cmd_type;

   typedef struct {
      logic                      ok;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        count;
      logic                      is_empty;
      logic                      is_full;
   } list_result_type;

   // values that recur on purpose so removes find duplicates and the extremes
   localparam logic [VALUE_W-1:0] HOT_VALUES [8] = '{
      32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0000,
      32'h7fff_ffff, 32'h0000_002a, 32'h5555_5555, 32'haaaa_aaaa
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // cmd, value, position, zero fill
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // ok, read_value, count, is_empty, is_full

   list_cmd_type    pending_cmds[$];
   list_result_type expected_results[$];

   // predicted contents of the list
   logic [VALUE_W-1:0] list_image [LIST_DEPTH];
   int unsigned        list_count = 0;

   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned sink_stall = 0;
   int unsigned sink_calm = 0;
   int unsigned mismatch_count = 0;

   bounded_array_list #(
      .CAPACITY(LIST_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #10 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // idle length: mostly none or short, now and then long, with calm stretches of none at all
   function automatic int unsigned next_gap(inout int unsigned calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if (roll == 0) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // applies one command to the predicted list and returns the result it must produce
   function automatic list_result_type apply_list_cmd(list_cmd_type c);
      list_result_type r;
      int unsigned     hit;
      r.ok = 1'b0;
      r.read_value = '0;
      case (c.cmd)
         CMD_APPEND: begin
            if (list_count < LIST_DEPTH) begin
               list_image[list_count] = c.value;
               list_count++;
               r.ok = 1'b1;
            end
         end
         CMD_REMOVE: begin
            // only the lowest-positioned match goes, later entries close the gap
            hit = 0;
            while (hit < list_count && list_image[hit] != c.value) hit++;
            if (hit < list_count) begin
               for (int unsigned i = hit + 1; i < list_count; i++)
                  list_image[i-1] = list_image[i];
               list_count--;
               r.ok = 1'b1;
            end
         end
         CMD_READ: begin
            if (c.position < list_count) begin
               r.read_value = list_image[c.position];
               r.ok = 1'b1;
            end
         end
         default: ;  // unused code leaves the list alone and fails
      endcase
      r.count = COUNT_W'(list_count);
      r.is_empty = (list_count == 0);
      r.is_full = (list_count == LIST_DEPTH);
      return r;
   endfunction

   function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] position, bit drain);
      list_cmd_type c;
      c.cmd = cmd;
      c.value = value;
      c.position = position;
      c.drain = drain;
      pending_cmds.push_back(c);
   endfunction

   // request driver: presents the head of the pending queue, predicts on each transfer
   always @(posedge clock) begin : drive_requests
      list_result_type outcome;
      logic            holding;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         holding = req_tvalid;
         if (req_tvalid && req_tready) begin
            outcome = apply_list_cmd(pending_cmds[0]);
            expected_results.push_back(outcome);
            pending_cmds.delete(0);
            holding = 1'b0;
            send_gap = next_gap(send_calm);
         end
         if (!holding) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (pending_cmds.size() != 0 &&
                         (!pending_cmds[0].drain || expected_results.size() == 0)) begin
               holding = 1'b1;
               req_tdata <= {1'b0, pending_cmds[0].position, pending_cmds[0].value,
                             pending_cmds[0].cmd};
            end
         end
         // valid gets exactly one update per edge so a held item never blinks
         req_tvalid <= holding;
      end
   end

   // result monitor: checks every transfer against the oldest prediction, stalls at random
   always @(posedge clock) begin : check_results
      list_result_type got;
      list_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok = rsp_tdata[0];
            got.read_value = rsp_tdata[32:1];
            got.count = rsp_tdata[38:33];
            got.is_empty = rsp_tdata[39];
            got.is_full = rsp_tdata[40];
            if (expected_results.size() == 0) begin
               $error("result transfer with no command outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, got.ok);
                  mismatch_count++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         got.read_value);
                  mismatch_count++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, got.count);
                  mismatch_count++;
               end
               if (got.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                  mismatch_count++;
               end
               if (got.is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
                  mismatch_count++;
               end
            end
            sink_stall = next_gap(sink_calm);
         end
         // the stall counts down whether or not a result is waiting, so it hits every phase
         if (sink_stall != 0) begin
            sink_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      logic [VALUE_W-1:0] seen_values[$];
      logic [VALUE_W-1:0] v;
      int unsigned        made;
      int unsigned        phase_kind;
      int unsigned        phase_len;
      int unsigned        roll;
      int unsigned        append_pct;
      int unsigned        remove_pct;
      logic [POS_W-1:0]   p;

      // directed: failures on an empty list, the unused code, extremes and duplicates
      add_cmd(CMD_READ,   32'h0000_0000, 5'd0,  1'b0);
      add_cmd(CMD_REMOVE, 32'h0000_0000, 5'd0,  1'b0);
      add_cmd(CMD_UNUSED, 32'hffff_ffff, 5'd31, 1'b0);
      add_cmd(CMD_APPEND, 32'h8000_0000, 5'd31, 1'b0);
      add_cmd(CMD_APPEND, 32'h7fff_ffff, 5'd0,  1'b0);
      add_cmd(CMD_APPEND, 32'h0000_0005, 5'd0,  1'b0);
      add_cmd(CMD_APPEND, 32'h0000_0005, 5'd0,  1'b0);
      add_cmd(CMD_APPEND, 32'hffff_ffff, 5'd0,  1'b0);
      add_cmd(CMD_READ,   32'h0000_0000, 5'd0,  1'b0);
      add_cmd(CMD_READ,   32'hffff_ffff, 5'd1,  1'b0);
      add_cmd(CMD_READ,   32'h0000_0000, 5'd2,  1'b0);
      add_cmd(CMD_READ,   32'h0000_0000, 5'd4,  1'b0);
      add_cmd(CMD_READ,   32'h0000_0000, 5'd5,  1'b0);   // position equal to count
      add_cmd(CMD_READ,   32'h0000_0000, 5'd31, 1'b0);
      add_cmd(CMD_REMOVE, 32'h0000_0005, 5'd0,  1'b0);   // only the first of the pair goes
      add_cmd(CMD_READ,   32'h0000_0000, 5'd2,  1'b0);
      add_cmd(CMD_READ,   32'h0000_0000, 5'd3,  1'b0);
      add_cmd(CMD_REMOVE, 32'h0000_04d2, 5'd0,  1'b0);   // absent value
      add_cmd(CMD_REMOVE, 32'h8000_0000, 5'd0,  1'b0);   // head entry
      add_cmd(CMD_REMOVE, 32'hffff_ffff, 5'd0,  1'b0);   // tail entry
      add_cmd(CMD_UNUSED, 32'h0000_0000, 5'd0,  1'b0);

      // random: phases that lean toward filling, draining or neither
      made = 0;
      while (made < RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len = $urandom_range(40, 120);
         case (phase_kind)
            0:       begin append_pct = 65; remove_pct = 15; end
            1:       begin append_pct = 15; remove_pct = 63; end
            default: begin append_pct = 35; remove_pct = 30; end
         endcase
         for (int unsigned k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 2) == 0)
               v = HOT_VALUES[$urandom_range(0, 7)];
            else
               v = $urandom;
            if ($urandom_range(0, 9) < 4)
               p = POS_W'($urandom_range(0, 7));
            else
               p = POS_W'($urandom_range(0, LIST_DEPTH - 1));
            if (roll < append_pct) begin
               add_cmd(CMD_APPEND, v, p, made == 0 || (k == 0 && $urandom_range(0, 3) == 0));
               seen_values.push_back(v);
               if (seen_values.size() > 64) seen_values.delete(0);
            end else if (roll < append_pct + remove_pct) begin
               // mostly a value that went in recently, so most removes find a match
               if (seen_values.size() != 0 && $urandom_range(0, 99) < 70)
                  v = seen_values[$urandom_range(0, seen_values.size() - 1)];
               add_cmd(CMD_REMOVE, v, p, 1'b0);
            end else if (roll < 98) begin
               add_cmd(CMD_READ, v, p, 1'b0);
            end else begin
               add_cmd(CMD_UNUSED, v, p, 1'b0);
            end
            made++;
         end
      end

      // everything sent and answered, then a quiet tail to catch stray results
      @(negedge reset);
      while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("bounded_array_list: match");
      end else begin
         $display("bounded_array_list: mismatch");
      end
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #60_000_000;
      $display("bounded_array_list: mismatch");
      $finish;
   end

endmodule
